>>> rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

>>> rtl/tufn_pkg.sv
`timescale 1ns / 1ps
package tufn_pkg;
   localparam int CoordWidth  = 24;
   localparam int IndexWidth  = 16;
   localparam int NormWidth   = 16;
   localparam int FracBits    = 14;
   localparam int EdgeWidth   = CoordWidth + 1;
   localparam int ProdWidth   = 2 * EdgeWidth;
   localparam int CrossWidth  = ProdWidth + 1;
   localparam int MagWidth    = ProdWidth;
   localparam int HalfWidth   = MagWidth / 2;
   localparam int SqWidth     = 2 * MagWidth;
   localparam int SumWidth    = SqWidth;
   localparam int RhsShift    = 2 * FracBits + 2;
   localparam int DiffWidth   = SumWidth + RhsShift + 3;
   localparam int ErrWidth    = SumWidth + FracBits + 3;
   localparam int QuotWidth   = FracBits + 1;
   localparam int BitWidth    = $clog2(QuotWidth);
   localparam int ShWidth     = BitWidth + 2;
   localparam int RootStages  = FracBits + 1;

   typedef struct packed {
      logic signed [DiffWidth-1:0] d;
      logic signed [ErrWidth-1:0]  e;
      logic [QuotWidth-1:0]        q;
      logic                        neg;
   } lane_type;
endpackage

>>> rtl/tufn_root_stage.sv
`timescale 1ns / 1ps
// One bit of the rounded-quotient recurrence for one component.
// d holds m^2*4^(F+1) - (2q-1)^2*S, e holds (2q-1)*S.
module tufn_root_stage (
   input  logic                                clock,
   input  logic                                load,
   input  logic [tufn_pkg::BitWidth-1:0]       step_bit,
   input  logic [tufn_pkg::SumWidth-1:0]       s_in,
   input  tufn_pkg::lane_type                  lane_in,
   output tufn_pkg::lane_type                  lane_out_ff
);
   localparam int DW = tufn_pkg::DiffWidth;
   localparam int EW = tufn_pkg::ErrWidth;
   localparam int QW = tufn_pkg::QuotWidth;
   localparam int SH = tufn_pkg::ShWidth;

   logic [SH-1:0]        sh_e;
   logic [SH-1:0]        sh_s;
   logic [SH-1:0]        sh_u;
   logic signed [DW-1:0] term;
   logic signed [DW-1:0] d_t;
   logic [QW-1:0]        q_t;
   logic                 take;
   tufn_pkg::lane_type   lane_in_next;

   always_comb begin
      sh_e = SH'(step_bit) + SH'(2);
      sh_s = (SH'(step_bit) << 1) + SH'(2);
      sh_u = SH'(step_bit) + SH'(1);
      term = (DW'($signed(lane_in.e)) <<< sh_e) + $signed(DW'(s_in) << sh_s);
      d_t  = $signed(lane_in.d) - term;
      q_t  = lane_in.q | (QW'(1) << step_bit);
      // once q reaches the full-scale value no further bit may be set
      take = !lane_in.q[QW-1] && !d_t[DW-1];
      lane_in_next = lane_in;
      if (take) begin
         lane_in_next.q = q_t;
         lane_in_next.d = d_t;
         lane_in_next.e = $signed(lane_in.e) + $signed(EW'(s_in) << sh_u);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         lane_out_ff <= lane_in_next;
      end
   end
endmodule

>>> rtl/triangle_unit_face_normal_unit.sv
`timescale 1ns / 1ps
// Unit face normal: takes one triangle per cycle and returns one result per
// cycle at full throughput while the receiver holds rsp_ready. The pipeline
// holds the exact rounding recurrence, one quotient bit per stage for 15
// stages, after nine stages of input, edge, cross product and sum-of-squares
// arithmetic and before one output stage. Each stage stalls only when it is
// full and the stage after it cannot move, so bubbles close up.
// A triangle whose cross product is zero gives a zero normal with the
// degenerate flag set.
module triangle_unit_face_normal_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [tufn_pkg::CoordWidth-1:0] req_a_x,
   input  logic signed [tufn_pkg::CoordWidth-1:0] req_a_y,
   input  logic signed [tufn_pkg::CoordWidth-1:0] req_a_z,
   input  logic signed [tufn_pkg::CoordWidth-1:0] req_b_x,
   input  logic signed [tufn_pkg::CoordWidth-1:0] req_b_y,
   input  logic signed [tufn_pkg::CoordWidth-1:0] req_b_z,
   input  logic signed [tufn_pkg::CoordWidth-1:0] req_c_x,
   input  logic signed [tufn_pkg::CoordWidth-1:0] req_c_y,
   input  logic signed [tufn_pkg::CoordWidth-1:0] req_c_z,
   input  logic [tufn_pkg::IndexWidth-1:0]        req_entry_index,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [tufn_pkg::NormWidth-1:0]  rsp_normal_x,
   output logic signed [tufn_pkg::NormWidth-1:0]  rsp_normal_y,
   output logic signed [tufn_pkg::NormWidth-1:0]  rsp_normal_z,
   output logic [tufn_pkg::IndexWidth-1:0]        rsp_result_index,
   output logic                                   rsp_degenerate
);
   localparam int CW = tufn_pkg::CoordWidth;
   localparam int XW = tufn_pkg::EdgeWidth;
   localparam int PW = tufn_pkg::ProdWidth;
   localparam int NW = tufn_pkg::CrossWidth;
   localparam int MW = tufn_pkg::MagWidth;
   localparam int HW = tufn_pkg::HalfWidth;
   localparam int QS = tufn_pkg::SqWidth;
   localparam int SW = tufn_pkg::SumWidth;
   localparam int DW = tufn_pkg::DiffWidth;
   localparam int EW = tufn_pkg::ErrWidth;
   localparam int OW = tufn_pkg::NormWidth;
   localparam int IW = tufn_pkg::IndexWidth;
   localparam int BW = tufn_pkg::BitWidth;
   localparam int RS = tufn_pkg::RootStages;
   localparam int RootFirst = 9;
   localparam int NumStages = RootFirst + RS + 1;
   localparam int LastStage = NumStages - 1;

   logic [NumStages-1:0] valid_ff;
   logic [NumStages:0]   adv;
   logic [IW-1:0]        idx_ff [NumStages];
   logic                 degen_ff [4:LastStage];

   // stage 0: input
   logic signed [CW-1:0] vtx_ff [9];
   // stage 1: edges
   logic signed [XW-1:0] px_ff, py_ff, pz_ff, qx_ff, qy_ff, qz_ff;
   // stage 2: products
   logic signed [PW-1:0] prod_ff [6];
   // stage 3: cross product
   logic signed [NW-1:0] cross_ff [3];
   // stage 4: magnitude and sign
   logic [MW-1:0]        mag_ff [3];
   logic                 neg_ff [4:RootFirst-2][3];
   // stage 5: partial squares
   logic [2*HW-1:0]      hh_ff [3];
   logic [2*HW-1:0]      hl_ff [3];
   logic [2*HW-1:0]      ll_ff [3];
   // stage 6: squares, stage 7: sum
   logic [QS-1:0]        sq_ff [6:7][3];
   logic [SW-1:0]        s_ff [7:RootFirst+RS-2];
   // stage 8: recurrence start
   tufn_pkg::lane_type   lane_init_ff [3];
   tufn_pkg::lane_type   lane_ff [RS][3];
   // output stage
   logic signed [OW-1:0] norm_ff [3];

   always_comb begin
      adv[NumStages] = rsp_ready;
      for (int k = NumStages - 1; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign req_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int k = 1; k < NumStages; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         idx_ff[0] <= req_entry_index;
         vtx_ff[0] <= req_a_x;
         vtx_ff[1] <= req_a_y;
         vtx_ff[2] <= req_a_z;
         vtx_ff[3] <= req_b_x;
         vtx_ff[4] <= req_b_y;
         vtx_ff[5] <= req_b_z;
         vtx_ff[6] <= req_c_x;
         vtx_ff[7] <= req_c_y;
         vtx_ff[8] <= req_c_z;
      end
      for (int k = 1; k < NumStages; k++) begin
         if (adv[k]) begin
            idx_ff[k] <= idx_ff[k-1];
         end
      end
      for (int k = 5; k < NumStages; k++) begin
         if (adv[k]) begin
            degen_ff[k] <= degen_ff[k-1];
         end
      end
      for (int k = 5; k < RootFirst - 1; k++) begin
         if (adv[k]) begin
            for (int c = 0; c < 3; c++) begin
               neg_ff[k][c] <= neg_ff[k-1][c];
            end
         end
      end
      for (int k = 8; k < RootFirst + RS - 1; k++) begin
         if (adv[k]) begin
            s_ff[k] <= s_ff[k-1];
         end
      end

      if (adv[1]) begin
         px_ff <= XW'(vtx_ff[3]) - XW'(vtx_ff[0]);
         py_ff <= XW'(vtx_ff[4]) - XW'(vtx_ff[1]);
         pz_ff <= XW'(vtx_ff[5]) - XW'(vtx_ff[2]);
         qx_ff <= XW'(vtx_ff[6]) - XW'(vtx_ff[0]);
         qy_ff <= XW'(vtx_ff[7]) - XW'(vtx_ff[1]);
         qz_ff <= XW'(vtx_ff[8]) - XW'(vtx_ff[2]);
      end
      if (adv[2]) begin
         prod_ff[0] <= PW'(py_ff) * PW'(qz_ff);
         prod_ff[1] <= PW'(pz_ff) * PW'(qy_ff);
         prod_ff[2] <= PW'(pz_ff) * PW'(qx_ff);
         prod_ff[3] <= PW'(px_ff) * PW'(qz_ff);
         prod_ff[4] <= PW'(px_ff) * PW'(qy_ff);
         prod_ff[5] <= PW'(py_ff) * PW'(qx_ff);
      end
      if (adv[3]) begin
         for (int c = 0; c < 3; c++) begin
            cross_ff[c] <= NW'(prod_ff[2*c]) - NW'(prod_ff[2*c+1]);
         end
      end
      if (adv[4]) begin
         // degenerate flag enters at stage 4, taken from the cross product
         degen_ff[4] <= (cross_ff[0] == '0) && (cross_ff[1] == '0)
                      && (cross_ff[2] == '0);
         for (int c = 0; c < 3; c++) begin
            mag_ff[c]    <= cross_ff[c][NW-1] ? MW'(-cross_ff[c]) : MW'(cross_ff[c]);
            neg_ff[4][c] <= cross_ff[c][NW-1];
         end
      end
      if (adv[5]) begin
         for (int c = 0; c < 3; c++) begin
            hh_ff[c] <= (2*HW)'(mag_ff[c][MW-1:HW]) * (2*HW)'(mag_ff[c][MW-1:HW]);
            hl_ff[c] <= (2*HW)'(mag_ff[c][MW-1:HW]) * (2*HW)'(mag_ff[c][HW-1:0]);
            ll_ff[c] <= (2*HW)'(mag_ff[c][HW-1:0]) * (2*HW)'(mag_ff[c][HW-1:0]);
         end
      end
      if (adv[6]) begin
         for (int c = 0; c < 3; c++) begin
            sq_ff[6][c] <= (QS'(hh_ff[c]) << (2*HW)) + (QS'(hl_ff[c]) << (HW+1))
                         + QS'(ll_ff[c]);
         end
      end
      if (adv[7]) begin
         s_ff[7] <= SW'(sq_ff[6][0]) + SW'(sq_ff[6][1]) + SW'(sq_ff[6][2]);
         for (int c = 0; c < 3; c++) begin
            sq_ff[7][c] <= sq_ff[6][c];
         end
      end
      if (adv[8]) begin
         for (int c = 0; c < 3; c++) begin
            lane_init_ff[c].d   <= $signed(DW'(sq_ff[7][c]) << tufn_pkg::RhsShift)
                                 - $signed(DW'(s_ff[7]));
            lane_init_ff[c].e   <= -$signed(EW'(s_ff[7]));
            lane_init_ff[c].q   <= '0;
            lane_init_ff[c].neg <= neg_ff[RootFirst-2][c];
         end
      end
      if (adv[LastStage]) begin
         for (int c = 0; c < 3; c++) begin
            if (degen_ff[LastStage-1]) begin
               norm_ff[c] <= '0;
            end else if (lane_ff[RS-1][c].neg) begin
               norm_ff[c] <= -OW'(lane_ff[RS-1][c].q);
            end else begin
               norm_ff[c] <= OW'(lane_ff[RS-1][c].q);
            end
         end
      end
   end

   for (genvar j = 0; j < RS; j++) begin : g_root
      for (genvar c = 0; c < 3; c++) begin : g_lane
         tufn_root_stage u_stage (
            .clock       (clock),
            .load        (adv[RootFirst+j]),
            .step_bit    (BW'(RS - 1 - j)),
            .s_in        (s_ff[RootFirst+j-1]),
            .lane_in     ((j == 0) ? lane_init_ff[c] : lane_ff[(j == 0) ? 0 : j-1][c]),
            .lane_out_ff (lane_ff[j][c])
         );
      end
   end

   assign rsp_valid        = valid_ff[LastStage];
   assign rsp_normal_x     = norm_ff[0];
   assign rsp_normal_y     = norm_ff[1];
   assign rsp_normal_z     = norm_ff[2];
   assign rsp_result_index = idx_ff[LastStage];
   assign rsp_degenerate   = degen_ff[LastStage];
endmodule

>>> rtl/tufn_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tufn_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_ready,
   input logic signed [tufn_pkg::CoordWidth-1:0] req_a_x,
   input logic signed [tufn_pkg::CoordWidth-1:0] req_a_y,
   input logic signed [tufn_pkg::CoordWidth-1:0] req_a_z,
   input logic signed [tufn_pkg::CoordWidth-1:0] req_b_x,
   input logic signed [tufn_pkg::CoordWidth-1:0] req_b_y,
   input logic signed [tufn_pkg::CoordWidth-1:0] req_b_z,
   input logic signed [tufn_pkg::CoordWidth-1:0] req_c_x,
   input logic signed [tufn_pkg::CoordWidth-1:0] req_c_y,
   input logic signed [tufn_pkg::CoordWidth-1:0] req_c_z,
   input logic [tufn_pkg::IndexWidth-1:0]        req_entry_index,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic signed [tufn_pkg::NormWidth-1:0]  rsp_normal_x,
   input logic signed [tufn_pkg::NormWidth-1:0]  rsp_normal_y,
   input logic signed [tufn_pkg::NormWidth-1:0]  rsp_normal_z,
   input logic [tufn_pkg::IndexWidth-1:0]        rsp_result_index,
   input logic                                   rsp_degenerate
);
   localparam int OW = tufn_pkg::NormWidth;
   localparam logic signed [OW-1:0] Full = OW'(1 << tufn_pkg::FracBits);

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_index) && $stable(rsp_normal_x))
   `ASSERT_CLK(a_degen_zero, clock, reset, rsp_valid && rsp_degenerate |-> rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0)
   `ASSERT_CLK(a_range, clock, reset, rsp_valid |-> rsp_normal_x <= Full && rsp_normal_x >= -Full && rsp_normal_z <= Full && rsp_normal_z >= -Full)
   `ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_valid)
   `ASSERT_CLK(a_nondegen_nonzero, clock, reset, rsp_valid && !rsp_degenerate |-> rsp_normal_x != '0 || rsp_normal_y != '0 || rsp_normal_z != '0)
endmodule

bind triangle_unit_face_normal_unit tufn_checker u_tufn_checker (.*);

>>> bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
   localparam int CW = tufn_pkg::CoordWidth;
   localparam int IW = tufn_pkg::IndexWidth;
   localparam int OW = tufn_pkg::NormWidth;
   localparam int QW = tufn_pkg::QuotWidth;
   localparam int HoldCycles = 300;
   localparam int StallLimit = 3000;
   localparam int DrainCycles = 60;
   localparam logic signed [CW-1:0] CMax = 24'sh7FFFFF;
   localparam logic signed [CW-1:0] CMin = 24'sh800000;
   localparam logic signed [OW-1:0] One = 16'sd16384;

   typedef struct packed {
      logic signed [CW-1:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
      logic [IW-1:0]        index;
   } triangle_type;

   typedef struct packed {
      logic signed [OW-1:0] n_x, n_y, n_z;
      logic [IW-1:0]        index;
      logic                 degenerate;
   } normal_type;

   typedef struct packed {
      triangle_type vtx;
      logic         typed;
      normal_type   known;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   triangle_type req_tri = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   normal_type rsp;

   normal_type pending_normals[$];
   normal_type typed_normals[$];
   logic typed_flags[$];
   int errors = 0;
   int phase = 0;
   int sent = 0;
   int received = 0;
   int degenerate_seen = 0;
   int idle_cycles = 0;

   always #4 clock = ~clock;

   triangle_unit_face_normal_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_a_x(req_tri.a_x), .req_a_y(req_tri.a_y), .req_a_z(req_tri.a_z),
      .req_b_x(req_tri.b_x), .req_b_y(req_tri.b_y), .req_b_z(req_tri.b_z),
      .req_c_x(req_tri.c_x), .req_c_y(req_tri.c_y), .req_c_z(req_tri.c_z),
      .req_entry_index(req_tri.index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_normal_x(rsp.n_x), .rsp_normal_y(rsp.n_y), .rsp_normal_z(rsp.n_z),
      .rsp_result_index(rsp.index), .rsp_degenerate(rsp.degenerate)
   );

   // Exact unit normal: largest q with (2q-1)^2 * |n|^2 <= m^2 * 4^(F+1).
   function automatic normal_type face_normal(input triangle_type t);
      logic signed [tufn_pkg::EdgeWidth-1:0] px, py, pz, qx, qy, qz;
      logic signed [tufn_pkg::CrossWidth-1:0] cr[3];
      logic [191:0] mag[3];
      logic [191:0] sum_sq, rhs, odd;
      logic [QW-1:0] q, trial;
      normal_type r;
      px = {t.b_x[23], t.b_x} - {t.a_x[23], t.a_x};
      py = {t.b_y[23], t.b_y} - {t.a_y[23], t.a_y};
      pz = {t.b_z[23], t.b_z} - {t.a_z[23], t.a_z};
      qx = {t.c_x[23], t.c_x} - {t.a_x[23], t.a_x};
      qy = {t.c_y[23], t.c_y} - {t.a_y[23], t.a_y};
      qz = {t.c_z[23], t.c_z} - {t.a_z[23], t.a_z};
      cr[0] = py * qz - pz * qy;
      cr[1] = pz * qx - px * qz;
      cr[2] = px * qy - py * qx;
      r = '0;
      r.index = t.index;
      if (cr[0] == 0 && cr[1] == 0 && cr[2] == 0) begin
         r.degenerate = 1'b1;
         return r;
      end
      sum_sq = '0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = cr[i] < 0 ? 192'(-cr[i]) : 192'(cr[i]);
         sum_sq += mag[i] * mag[i];
      end
      for (int i = 0; i < 3; i++) begin
         rhs = (mag[i] * mag[i]) << tufn_pkg::RhsShift;
         q = '0;
         for (int b = tufn_pkg::FracBits; b >= 0; b--) begin
            trial = q | (QW'(1) << b);
            if (trial > (QW'(1) << tufn_pkg::FracBits)) continue;
            odd = 192'(trial) * 2 - 1;
            if (odd * odd * sum_sq <= rhs) q = trial;
         end
         if (i == 0) r.n_x = cr[i] < 0 ? -$signed({1'b0, q}) : $signed({1'b0, q});
         if (i == 1) r.n_y = cr[i] < 0 ? -$signed({1'b0, q}) : $signed({1'b0, q});
         if (i == 2) r.n_z = cr[i] < 0 ? -$signed({1'b0, q}) : $signed({1'b0, q});
      end
      return r;
   endfunction

   task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
      errors++;
      $display("mismatch on %s: got %0h, want %0h (result %0d)", field, got, want, received);
   endtask

   // Prediction at request acceptance, checking at result acceptance.
   always @(posedge clock) begin
      normal_type want;
      if (!reset) begin
         if (req_valid && req_ready) pending_normals.push_back(face_normal(req_tri));
         if (req_valid && req_ready || rsp_valid && rsp_ready) idle_cycles = 0;
         else idle_cycles++;
         if (rsp_valid && rsp_ready) begin
            if (pending_normals.size() == 0) begin
               report("unexpected result", rsp.index, 0);
            end else begin
               want = pending_normals.pop_front();
               if (typed_flags.size() != 0) begin
                  if (typed_flags.pop_front()) want = typed_normals.pop_front();
               end
               if (rsp.n_x !== want.n_x) report("normal_x", rsp.n_x, want.n_x);
               if (rsp.n_y !== want.n_y) report("normal_y", rsp.n_y, want.n_y);
               if (rsp.n_z !== want.n_z) report("normal_z", rsp.n_z, want.n_z);
               if (rsp.index !== want.index) report("result_index", rsp.index, want.index);
               if (rsp.degenerate !== want.degenerate)
                  report("degenerate", rsp.degenerate, want.degenerate);
               degenerate_seen += rsp.degenerate;
            end
            received++;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && idle_cycles >= StallLimit) begin
         $display("timeout: no handshake for %0d cycles", StallLimit);
         $display("Test completed with failures");
         $finish;
      end
   end

   // Receiver; holds off once for a long stretch so the pipeline backs up.
   initial begin
      int hold;
      int stall_pct;
      bit held = 0;
      forever begin
         @(posedge clock);
         stall_pct = (phase == 2 || phase == 3) ? 45 : (phase == 4 ? 10 : 0);
         if (phase == 2 && !held) begin
            held = 1;
            hold = HoldCycles;
         end
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !reset && ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task automatic send(input triangle_type t);
      int idle_pct;
      idle_pct = (phase == 1 || phase == 3) ? 45 : (phase == 4 ? 10 : 0);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_tri <= t;
      req_valid <= 1'b1;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      sent++;
   endtask

   function automatic logic signed [CW-1:0] coord(input int kind);
      case (kind)
         0: return CW'($urandom);
         1: return $signed(24'($urandom_range(32))) - 24'sd16;
         2: return $urandom_range(1) ? CMax : CMin;
         default: return $signed(24'($urandom_range(4095))) - 24'sd2048;
      endcase
   endfunction

   function automatic triangle_type random_triangle();
      triangle_type t;
      int kind;
      int k;
      kind = $urandom_range(3);
      t.a_x = coord(kind); t.a_y = coord(kind); t.a_z = coord(kind);
      t.b_x = coord(kind); t.b_y = coord(kind); t.b_z = coord(kind);
      t.c_x = coord(kind); t.c_y = coord(kind); t.c_z = coord(kind);
      t.index = IW'($urandom);
      // A share of collinear or coincident vertices for degenerate results.
      if ($urandom_range(9) == 0) begin
         k = $urandom_range(3);
         t.a_x = coord(1); t.a_y = coord(1); t.a_z = coord(1);
         t.c_x = CW'(t.a_x + k * (t.b_x - t.a_x));
         t.c_y = CW'(t.a_y + k * (t.b_y - t.a_y));
         t.c_z = CW'(t.a_z + k * (t.b_z - t.a_z));
      end
      return t;
   endfunction

   directed_row_type directed[] = '{
      '{'{0, 0, 0, 0, 0, 0, 0, 0, 0, 16'h0000}, 1'b1, '{0, 0, 0, 16'h0000, 1'b1}},
      '{'{0, 0, 0, 256, 0, 0, 0, 256, 0, 16'h0001}, 1'b1, '{0, 0, One, 16'h0001, 1'b0}},
      '{'{0, 0, 0, 0, 256, 0, 256, 0, 0, 16'hFFFF}, 1'b1, '{0, 0, -One, 16'hFFFF, 1'b0}},
      '{'{0, 0, 0, 0, 1, 0, 0, 0, 1, 16'h0003}, 1'b1, '{One, 0, 0, 16'h0003, 1'b0}},
      '{'{0, 0, 0, 0, 0, 1, 1, 0, 0, 16'h0004}, 1'b1, '{0, One, 0, 16'h0004, 1'b0}},
      '{'{CMax, CMax, CMax, CMax, CMax, CMax, CMax, CMax, CMax, 16'h0005}, 1'b1,
        '{0, 0, 0, 16'h0005, 1'b1}},
      '{'{CMin, CMin, CMin, CMax, CMin, CMin, CMin, CMax, CMin, 16'h8000}, 1'b1,
        '{0, 0, One, 16'h8000, 1'b0}},
      '{'{1, 2, 3, 2, 4, 6, 3, 6, 9, 16'h0007}, 1'b1, '{0, 0, 0, 16'h0007, 1'b1}},
      '{'{CMax, CMin, CMax, CMin, CMax, CMin, CMax, CMax, CMin, 16'h0008}, 1'b0, '0},
      '{'{CMin, CMax, CMin, CMax, CMin, CMax, CMin, CMin, CMax, 16'h5555}, 1'b0, '0},
      '{'{0, 0, 0, 1, 1, 0, 0, 1, 1, 16'hAAAA}, 1'b0, '0},
      '{'{-5, 7, -9, 11, -13, 17, 19, -23, 29, 16'h1234}, 1'b0, '0},
      '{'{CMax, 0, 0, 0, CMax, 0, 0, 0, CMax, 16'h00FF}, 1'b0, '0},
      '{'{CMin, 0, 0, 0, CMin, 0, 0, 0, CMin, 16'hFF00}, 1'b0, '0},
      '{'{0, 0, 0, CMax, 1, 0, 0, 1, 0, 16'h0F0F}, 1'b0, '0}
   };

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) begin
         typed_flags.push_back(directed[i].typed);
         if (directed[i].typed) typed_normals.push_back(directed[i].known);
         send(directed[i].vtx);
      end
      for (int p = 1; p <= 4; p++) begin
         phase = p;
         for (int i = 0; i < 175; i++) send(random_triangle());
      end
      req_valid <= 1'b0;
      while (pending_normals.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      $display("%0d triangles sent, %0d normals checked, %0d degenerate", sent, received,
               degenerate_seen);
      $display("covered full-range, small and collinear vertices under idle and stall phases");
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
